### src/hrp_pkg.sv
// Shared types, character codes and helper functions of the HTTP request parser.
package hrp_pkg;

    typedef enum logic [1:0] {
        PH_REQ_LINE = 2'd0,
        PH_HEADERS  = 2'd1,
        PH_BODY     = 2'd2,
        PH_DONE     = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_PARSING   = 3'd0,
        ST_COMPLETE  = 3'd1,
        ST_BAD_LINE  = 3'd2,
        ST_VERB_LONG = 3'd3,
        ST_URI_LONG  = 3'd4,
        ST_TOO_MUCH  = 3'd5,
        ST_OVERFLOW  = 3'd6,
        ST_IGNORED   = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        VP_SKIP   = 2'd0,
        VP_DIGITS = 2'd1,
        VP_DONE   = 2'd3
    } value_phase_t;

    localparam logic       OP_START = 1'b0;
    localparam logic       OP_DATA  = 1'b1;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;

    localparam logic [3:0]  NAME_LEN = 4'd14;
    localparam logic [10:0] LEN_SAT  = 11'd2047;
    localparam logic [19:0] VAL_SAT  = 20'd65535;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        status_t     status;
        phase_t      phase;
        logic        verb_byte;
        logic        uri_byte;
        logic        body_byte;
        logic [10:0] verb_length;
        logic [10:0] uri_length;
        logic [15:0] content_length;
    } result_t;

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= CH_UC_A && b <= CH_UC_Z) ? b + 8'd32 : b;
    endfunction

    function automatic logic is_white(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_VT || b == CH_FF;
    endfunction

    // lower-case "content-length", one character per index
    function automatic logic [7:0] cl_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h63;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2D;
            4'd8:    c = 8'h6C;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### src/hrp_item_if.sv
// Byte channel into the parser: valid, ready and one received item.
interface hrp_item_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

### src/hrp_result_if.sv
// Result channel out of the parser: valid, ready and one result item.
interface hrp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [1:0]  phase;
    logic        verb_byte;
    logic        uri_byte;
    logic        body_byte;
    logic [10:0] verb_length;
    logic [10:0] uri_length;
    logic [15:0] content_length;

    modport source (output valid, output status, output phase, output verb_byte,
                    output uri_byte, output body_byte, output verb_length,
                    output uri_length, output content_length, input ready);
    modport sink   (input valid, input status, input phase, input verb_byte,
                    input uri_byte, input body_byte, input verb_length,
                    input uri_length, input content_length, output ready);
endinterface

### src/http_request_header_parser_top.sv
// Top level of the HTTP request header parser: input register, parser core, result register.
//
//  channel  | dir | transfer contents
//  ---------+-----+-------------------------------------------------------------
//  item     | in  | op, data_byte
//  result   | out | status, phase, verb/uri/body marks, verb/uri length, content length
//
// One byte per cycle sustained while result.ready holds; each transfer yields one result.
// The rate is set by the parser state registers, which update once per advance.
// Reset clears all parser state and both stage valid flags; no clearing pass.
// A stalled result holds its register; the input register keeps accepting
// until both stages are full.
module http_request_header_parser_top #(
    parameter int BUF_SIZE = 1024,
    parameter int VERB_MAX = 16,
    parameter int URI_MAX  = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    hrp_item_if.sink      item,
    hrp_result_if.source  result
);

    logic             held_valid;
    hrp_pkg::item_t   held;
    hrp_pkg::result_t core_res;
    logic             out_free;
    logic             advance;

    assign advance = held_valid && out_free;

    hrp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .advance    (advance),
        .held_valid (held_valid),
        .held       (held)
    );

    hrp_core #(
        .BUF_SIZE (BUF_SIZE),
        .VERB_MAX (VERB_MAX),
        .URI_MAX  (URI_MAX)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .held    (held),
        .res     (core_res)
    );

    hrp_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .res    (core_res),
        .free   (out_free),
        .result (result)
    );

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result.valid)
        else $error("loaded result not presented");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && held.op == hrp_pkg::OP_START |-> core_res == '0)
        else $error("start item gave a non-zero result");

    a_ignored_done: assert property (@(posedge clk) disable iff (!rst_n)
        advance && core_res.status == hrp_pkg::ST_IGNORED |-> core_res.phase == hrp_pkg::PH_DONE)
        else $error("ignored byte outside the finished phase");

    a_marks_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> $onehot0({core_res.verb_byte, core_res.uri_byte, core_res.body_byte}))
        else $error("byte marked in more than one region");

endmodule

### src/hrp_in_stage.sv
// Input register: holds one accepted item until the parser core takes it.
module hrp_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    hrp_item_if.sink           item,
    input  logic               advance,
    output logic               held_valid,
    output hrp_pkg::item_t     held
);

    logic           valid_reg;
    logic           valid_next;
    hrp_pkg::item_t item_reg;
    logic           take;

    assign item.ready = !valid_reg || advance;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.op        <= item.op;
            item_reg.data_byte <= item.data_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held       = item_reg;

endmodule

### src/hrp_core.sv
// Parser state and next-state logic: one byte of the request per advance.
module hrp_core #(
    parameter int BUF_SIZE = 1024,
    parameter int VERB_MAX = 16,
    parameter int URI_MAX  = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  hrp_pkg::item_t    held,
    output hrp_pkg::result_t  res
);

    localparam int PEND_W = $clog2(BUF_SIZE + 1);

    hrp_pkg::phase_t       phase_reg, phase_next;
    hrp_pkg::status_t      term_reg, term_next;
    logic [PEND_W-1:0]     pend_reg, pend_next;
    logic [1:0]            blank_reg, blank_next;
    logic [10:0]           verb_len_reg, verb_len_next;
    logic [10:0]           uri_len_reg, uri_len_next;
    logic                  prev_cr_reg, prev_cr_next;
    logic [3:0]            name_idx_reg, name_idx_next;
    logic                  mismatch_reg, mismatch_next;
    logic                  colon_reg, colon_next;
    hrp_pkg::value_phase_t vphase_reg, vphase_next;
    logic [15:0]           accum_reg, accum_next;
    logic [15:0]           body_len_reg, body_len_next;
    logic [15:0]           body_cnt_reg, body_cnt_next;

    logic [7:0]  b;
    logic        is_data;
    logic        line_open;
    logic [19:0] scaled;
    logic [15:0] body_cnt_inc;
    logic        empty_line;

    assign b            = held.data_byte;
    assign is_data      = held.op == hrp_pkg::OP_DATA;
    assign line_open    = pend_reg < PEND_W'(BUF_SIZE);
    assign scaled       = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                          + {12'd0, b - hrp_pkg::CH_ZERO};
    assign body_cnt_inc = body_cnt_reg + 16'd1;
    assign empty_line   = (pend_reg == '0) || (pend_reg == PEND_W'(1) && prev_cr_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        term_next     = term_reg;
        pend_next     = pend_reg;
        blank_next    = blank_reg;
        verb_len_next = verb_len_reg;
        uri_len_next  = uri_len_reg;
        prev_cr_next  = prev_cr_reg;
        name_idx_next = name_idx_reg;
        mismatch_next = mismatch_reg;
        colon_next    = colon_reg;
        vphase_next   = vphase_reg;
        accum_next    = accum_reg;
        body_len_next = body_len_reg;
        body_cnt_next = body_cnt_reg;

        if (!is_data)
        begin
            phase_next    = hrp_pkg::PH_REQ_LINE;
            term_next     = hrp_pkg::ST_PARSING;
            pend_next     = '0;
            blank_next    = 2'd0;
            verb_len_next = 11'd0;
            uri_len_next  = 11'd0;
            prev_cr_next  = 1'b0;
            name_idx_next = 4'd0;
            mismatch_next = 1'b0;
            colon_next    = 1'b0;
            vphase_next   = hrp_pkg::VP_SKIP;
            accum_next    = 16'd0;
            body_len_next = 16'd0;
            body_cnt_next = 16'd0;
        end
        else
        begin
            case (phase_reg)
                hrp_pkg::PH_DONE:
                begin
                end
                hrp_pkg::PH_BODY:
                begin
                    body_cnt_next = body_cnt_inc;
                    if (body_cnt_inc >= body_len_reg)
                    begin
                        phase_next = hrp_pkg::PH_DONE;
                        term_next  = hrp_pkg::ST_COMPLETE;
                    end
                end
                default:
                begin
                    if (!line_open)
                    begin
                        phase_next = hrp_pkg::PH_DONE;
                        term_next  = hrp_pkg::ST_OVERFLOW;
                    end
                    else if (b == hrp_pkg::CH_LF)
                    begin
                        if (phase_reg == hrp_pkg::PH_REQ_LINE)
                        begin
                            if (blank_reg < 2'd2)
                            begin
                                phase_next = hrp_pkg::PH_DONE;
                                term_next  = hrp_pkg::ST_BAD_LINE;
                            end
                            else if (verb_len_reg > 11'(VERB_MAX))
                            begin
                                phase_next = hrp_pkg::PH_DONE;
                                term_next  = hrp_pkg::ST_VERB_LONG;
                            end
                            else if (uri_len_reg >= 11'(URI_MAX))
                            begin
                                phase_next = hrp_pkg::PH_DONE;
                                term_next  = hrp_pkg::ST_URI_LONG;
                            end
                            else
                            begin
                                phase_next = hrp_pkg::PH_HEADERS;
                            end
                        end
                        else if (empty_line)
                        begin
                            if (body_len_reg > 16'(BUF_SIZE))
                            begin
                                phase_next = hrp_pkg::PH_DONE;
                                term_next  = hrp_pkg::ST_TOO_MUCH;
                            end
                            else if (body_len_reg != 16'd0)
                            begin
                                phase_next = hrp_pkg::PH_BODY;
                            end
                            else
                            begin
                                phase_next = hrp_pkg::PH_DONE;
                                term_next  = hrp_pkg::ST_COMPLETE;
                            end
                        end
                        else if (colon_reg && !mismatch_reg && name_idx_reg == hrp_pkg::NAME_LEN)
                        begin
                            body_len_next = accum_reg;
                        end
                        pend_next     = '0;
                        prev_cr_next  = 1'b0;
                        name_idx_next = 4'd0;
                        mismatch_next = 1'b0;
                        colon_next    = 1'b0;
                        vphase_next   = hrp_pkg::VP_SKIP;
                        accum_next    = 16'd0;
                    end
                    else
                    begin
                        pend_next    = pend_reg + PEND_W'(1);
                        prev_cr_next = b == hrp_pkg::CH_CR;
                        if (phase_reg == hrp_pkg::PH_REQ_LINE)
                        begin
                            if (b == hrp_pkg::CH_SPACE)
                            begin
                                if (blank_reg != 2'd3)
                                begin
                                    blank_next = blank_reg + 2'd1;
                                end
                            end
                            else if (blank_reg == 2'd0)
                            begin
                                if (verb_len_reg != hrp_pkg::LEN_SAT)
                                begin
                                    verb_len_next = verb_len_reg + 11'd1;
                                end
                            end
                            else if (blank_reg == 2'd1)
                            begin
                                if (uri_len_reg != hrp_pkg::LEN_SAT)
                                begin
                                    uri_len_next = uri_len_reg + 11'd1;
                                end
                            end
                        end
                        else if (!colon_reg)
                        begin
                            if (b == hrp_pkg::CH_COLON)
                            begin
                                colon_next = 1'b1;
                            end
                            else if (name_idx_reg < hrp_pkg::NAME_LEN
                                     && hrp_pkg::to_lower(b) == hrp_pkg::cl_char(name_idx_reg))
                            begin
                                name_idx_next = name_idx_reg + 4'd1;
                            end
                            else
                            begin
                                mismatch_next = 1'b1;
                            end
                        end
                        else if (vphase_reg == hrp_pkg::VP_SKIP && hrp_pkg::is_white(b))
                        begin
                        end
                        else if (vphase_reg == hrp_pkg::VP_SKIP && b == hrp_pkg::CH_PLUS)
                        begin
                            vphase_next = hrp_pkg::VP_DIGITS;
                        end
                        else if (vphase_reg == hrp_pkg::VP_SKIP && b == hrp_pkg::CH_MINUS)
                        begin
                            accum_next  = 16'd0;
                            vphase_next = hrp_pkg::VP_DONE;
                        end
                        else if (vphase_reg != hrp_pkg::VP_DONE)
                        begin
                            if (b >= hrp_pkg::CH_ZERO && b <= hrp_pkg::CH_NINE)
                            begin
                                vphase_next = hrp_pkg::VP_DIGITS;
                                accum_next  = (scaled > hrp_pkg::VAL_SAT) ? 16'hFFFF
                                                                           : scaled[15:0];
                            end
                            else
                            begin
                                vphase_next = hrp_pkg::VP_DONE;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        res = '0;
        res.phase          = phase_next;
        res.verb_length    = verb_len_next;
        res.uri_length     = uri_len_next;
        res.content_length = body_len_next;
        if (is_data)
        begin
            if (phase_reg == hrp_pkg::PH_DONE)
            begin
                res.status = hrp_pkg::ST_IGNORED;
            end
            else if (phase_next == hrp_pkg::PH_DONE)
            begin
                res.status = term_next;
            end
            res.body_byte = phase_reg == hrp_pkg::PH_BODY;
            if (phase_reg == hrp_pkg::PH_REQ_LINE && line_open
                && b != hrp_pkg::CH_LF && b != hrp_pkg::CH_SPACE)
            begin
                res.verb_byte = blank_reg == 2'd0;
                res.uri_byte  = blank_reg == 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= hrp_pkg::PH_REQ_LINE;
            term_reg     <= hrp_pkg::ST_PARSING;
            pend_reg     <= '0;
            blank_reg    <= 2'd0;
            verb_len_reg <= 11'd0;
            uri_len_reg  <= 11'd0;
            prev_cr_reg  <= 1'b0;
            name_idx_reg <= 4'd0;
            mismatch_reg <= 1'b0;
            colon_reg    <= 1'b0;
            vphase_reg   <= hrp_pkg::VP_SKIP;
            accum_reg    <= 16'd0;
            body_len_reg <= 16'd0;
            body_cnt_reg <= 16'd0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            term_reg     <= term_next;
            pend_reg     <= pend_next;
            blank_reg    <= blank_next;
            verb_len_reg <= verb_len_next;
            uri_len_reg  <= uri_len_next;
            prev_cr_reg  <= prev_cr_next;
            name_idx_reg <= name_idx_next;
            mismatch_reg <= mismatch_next;
            colon_reg    <= colon_next;
            vphase_reg   <= vphase_next;
            accum_reg    <= accum_next;
            body_len_reg <= body_len_next;
            body_cnt_reg <= body_cnt_next;
        end
    end

endmodule

### src/hrp_out_stage.sv
// Result register: holds one result until the downstream side takes it.
module hrp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  hrp_pkg::result_t  res,
    output logic              free,
    hrp_result_if.source      result
);

    logic             valid_reg;
    logic             valid_next;
    hrp_pkg::result_t res_reg;

    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign result.valid          = valid_reg;
    assign result.status         = res_reg.status;
    assign result.phase          = res_reg.phase;
    assign result.verb_byte      = res_reg.verb_byte;
    assign result.uri_byte       = res_reg.uri_byte;
    assign result.body_byte      = res_reg.body_byte;
    assign result.verb_length    = res_reg.verb_length;
    assign result.uri_length     = res_reg.uri_length;
    assign result.content_length = res_reg.content_length;

endmodule
